@@ hw/rtl/cbd_pkg.sv @@
// Package for the chunked body decoder: phase enum, status and error codes, character classes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cbd_pkg;

  typedef enum logic [3:0] {
    PH_SIZE, PH_EXT, PH_SIZE_LF, PH_EXT_LF, PH_DATA, PH_DATA_CR, PH_DATA_LF,
    PH_TR_START, PH_TR_NAME, PH_TR_VAL, PH_TR_LF, PH_END_LF
  } phase_t;

  localparam logic [1:0] ST_BUSY = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;
  localparam logic [1:0] ST_BIG  = 2'd3;

  localparam logic [2:0] ER_NONE   = 3'd0;
  localparam logic [2:0] ER_SIZE   = 3'd1;
  localparam logic [2:0] ER_EXT    = 3'd2;
  localparam logic [2:0] ER_CRLF   = 3'd3;
  localparam logic [2:0] ER_TRAIL  = 3'd4;
  localparam logic [2:0] ER_FORBID = 3'd5;
  localparam logic [2:0] ER_BIG    = 3'd6;

  // Configuration register indexes
  localparam logic CFG_LIMIT = 1'b0;
  localparam logic CFG_KEEP  = 1'b1;

  localparam int unsigned NAME_MAX = 17;
  localparam logic [4:0] NAME_LEN [4] = '{5'd14, 5'd17, 5'd10, 5'd4};

  function automatic logic [7:0] name_char(input logic [1:0] idx, input logic [4:0] pos);
    logic [8*NAME_MAX-1:0] s;
    begin
      case (idx)
        2'd0:    s = {"content-length", 24'h0};
        2'd1:    s = "transfer-encoding";
        2'd2:    s = {"connection", 56'h0};
        default: s = {"host", 104'h0};
      endcase
      name_char = (pos < 5'(NAME_MAX)) ? s[8*(NAME_MAX-1-int'(pos)) +: 8] : 8'h0;
    end
  endfunction

  function automatic logic value_ok(input logic [7:0] c);
    value_ok = (c == 8'h09) || (c >= 8'd32 && c != 8'd127);
  endfunction

  function automatic logic token_ok(input logic [7:0] c);
    case (c)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "?",
      "{", "}", "=": token_ok = 1'b0;
      default:        token_ok = (c > 8'd32) && (c < 8'd127);
    endcase
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/chunked_body_decoder.sv @@
// Chunked HTTP/1.1 body decoder, top level.
// Depends on cbd_pkg.
//
// Usage: feed the raw chunked body one byte per beat on the in channel
// (in_byte, start_req). start_req clears all parse state before its byte,
// starting a new body. Each input beat yields exactly one output beat with
// the decoded byte (data_valid), status, error_code and consumed count.
// The output beat is registered on input acceptance; the block
// takes one byte per cycle, limited only by the single output register.
// When the receiver stalls, the result register holds and in_ready drops
// until it is taken. Reset restores body_limit=1 MiB, keep_data=1 and an
// empty parse state. Once status leaves in-progress it sticks; later bytes
// return the same status until start_req. Configure via cfg_we/cfg_index/
// cfg_data while idle.
`timescale 1ns / 1ps
`default_nettype none
module chunked_body_decoder
  import cbd_pkg::*;
#(
  parameter int SIZE_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        start_req,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             data_valid,
  output logic [7:0]       data_byte,
  output logic [1:0]       status,
  output logic [2:0]       error_code,
  output logic [31:0]      consumed,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic [31:0] body_limit;
  logic        keep_data;

  phase_t                phase, phase_next;
  logic [SIZE_BITS-1:0]  size_accum, size_accum_next;
  logic [31:0]           data_left, data_left_next;
  logic [31:0]           decoded_total, decoded_total_next;
  logic [31:0]           byte_count, byte_count_next;
  logic                  digit_seen, digit_seen_next;
  logic [3:0]            name_hits, name_hits_next;
  logic [4:0]            name_pos, name_pos_next;
  logic [1:0]            outcome, outcome_next;
  logic [2:0]            fault, fault_next;
  logic                  dv_next;

  logic take;
  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      body_limit <= 32'd1048576;
      keep_data  <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == CFG_LIMIT) body_limit <= cfg_data;
      else                        keep_data  <= cfg_data[0];
    end
  end

  // Effective current state after optional start clear
  phase_t               c_phase;
  logic [SIZE_BITS-1:0] c_size;
  logic [31:0]          c_left, c_total, c_count;
  logic                 c_seen;
  logic [3:0]           c_hits;
  logic [4:0]           c_pos;
  logic [1:0]           c_out;
  logic [2:0]           c_fault;
  logic [3:0]           hexv;
  logic                 is_hex;
  logic [7:0]           lc;
  logic [3:0]           hits_m;
  logic [32:0]          room;
  logic                 size_nz, over;

  always_comb begin
    if (start_req) begin
      c_phase = PH_SIZE; c_size = '0; c_left = '0; c_total = '0; c_count = '0;
      c_seen = 1'b0; c_hits = 4'hF; c_pos = '0; c_out = ST_BUSY; c_fault = ER_NONE;
    end else begin
      c_phase = phase; c_size = size_accum; c_left = data_left; c_total = decoded_total;
      c_count = byte_count; c_seen = digit_seen; c_hits = name_hits; c_pos = name_pos;
      c_out = outcome; c_fault = fault;
    end
  end

  always_comb begin
    is_hex = 1'b1;
    hexv   = 4'd0;
    if (in_byte >= "0" && in_byte <= "9")      hexv = 4'(in_byte - "0");
    else if (in_byte >= "a" && in_byte <= "f") hexv = 4'(in_byte - "a" + 8'd10);
    else if (in_byte >= "A" && in_byte <= "F") hexv = 4'(in_byte - "A" + 8'd10);
    else is_hex = 1'b0;
    lc = (in_byte >= "A" && in_byte <= "Z") ? (in_byte | 8'h20) : in_byte;
  end

  // Name match against forbidden trailer names; start_at_zero for first byte
  logic [3:0] hits_base;
  logic [4:0] pos_base;
  always_comb begin
    hits_base = (c_phase == PH_TR_START) ? 4'hF : c_hits;
    pos_base  = (c_phase == PH_TR_START) ? 5'd0 : c_pos;
    for (int i = 0; i < 4; i++) begin
      hits_m[i] = hits_base[i] && (pos_base < NAME_LEN[i]) &&
                  (name_char(2'(i), pos_base) == lc);
    end
  end

  always_comb begin
    room    = {1'b0, body_limit} - {1'b0, c_total};
    size_nz = (c_size != '0);
    over    = (c_total > body_limit) || ({{(64-SIZE_BITS){1'b0}}, c_size} >
              {31'd0, room});
  end

  always_comb begin
    phase_next = c_phase; size_accum_next = c_size; data_left_next = c_left;
    decoded_total_next = c_total; byte_count_next = c_count; digit_seen_next = c_seen;
    name_hits_next = c_hits; name_pos_next = c_pos; outcome_next = c_out;
    fault_next = c_fault; dv_next = 1'b0;
    if (c_out == ST_BUSY) begin
      if (c_count != 32'hFFFF_FFFF) byte_count_next = c_count + 32'd1;
      unique case (c_phase)
        PH_SIZE: begin
          if (is_hex) begin
            if (c_size[SIZE_BITS-1 -: 4] != 4'd0) begin
              outcome_next = ST_BIG; fault_next = ER_BIG;
            end else begin
              size_accum_next = {c_size[SIZE_BITS-5:0], hexv};
              digit_seen_next = 1'b1;
            end
          end else if (in_byte == ";" && c_seen) phase_next = PH_EXT;
          else if (in_byte == 8'h0D && c_seen)  phase_next = PH_SIZE_LF;
          else begin outcome_next = ST_BAD; fault_next = ER_SIZE; end
        end
        PH_EXT: begin
          if (in_byte == 8'h0D) phase_next = PH_EXT_LF;
          else if (!value_ok(in_byte)) begin outcome_next = ST_BAD; fault_next = ER_EXT; end
        end
        PH_SIZE_LF, PH_EXT_LF: begin
          if (in_byte == 8'h0A) begin
            if (!size_nz) phase_next = PH_TR_START;
            else if (over) begin outcome_next = ST_BIG; fault_next = ER_BIG; end
            else begin
              data_left_next = 32'(c_size);
              phase_next = PH_DATA;
            end
          end else begin
            outcome_next = ST_BAD;
            fault_next = (c_phase == PH_SIZE_LF) ? ER_SIZE : ER_EXT;
          end
        end
        PH_DATA: begin
          dv_next = keep_data;
          decoded_total_next = c_total + 32'd1;
          data_left_next = c_left - 32'd1;
          if (c_left == 32'd1) phase_next = PH_DATA_CR;
        end
        PH_DATA_CR: begin
          if (in_byte == 8'h0D) phase_next = PH_DATA_LF;
          else begin outcome_next = ST_BAD; fault_next = ER_CRLF; end
        end
        PH_DATA_LF: begin
          if (in_byte == 8'h0A) begin
            phase_next = PH_SIZE; size_accum_next = '0; digit_seen_next = 1'b0;
          end else begin outcome_next = ST_BAD; fault_next = ER_CRLF; end
        end
        PH_TR_START, PH_TR_NAME: begin
          if (c_phase == PH_TR_START && in_byte == 8'h0D) phase_next = PH_END_LF;
          else if (c_phase == PH_TR_NAME && in_byte == ":") begin
            for (int i = 0; i < 4; i++)
              name_hits_next[i] = c_hits[i] && (c_pos == NAME_LEN[i]);
            phase_next = PH_TR_VAL;
          end else if (token_ok(in_byte)) begin
            name_hits_next = hits_m;
            name_pos_next  = (pos_base < 5'd31) ? pos_base + 5'd1 : pos_base;
            phase_next = PH_TR_NAME;
          end else begin outcome_next = ST_BAD; fault_next = ER_TRAIL; end
        end
        PH_TR_VAL: begin
          if (in_byte == 8'h0D) phase_next = PH_TR_LF;
          else if (!value_ok(in_byte)) begin outcome_next = ST_BAD; fault_next = ER_TRAIL; end
        end
        PH_TR_LF: begin
          if (in_byte != 8'h0A) begin outcome_next = ST_BAD; fault_next = ER_TRAIL; end
          else if (c_hits != 4'd0) begin outcome_next = ST_BAD; fault_next = ER_FORBID; end
          else phase_next = PH_TR_START;
        end
        PH_END_LF: begin
          if (in_byte == 8'h0A) begin outcome_next = ST_DONE; fault_next = ER_NONE; end
          else begin outcome_next = ST_BAD; fault_next = ER_TRAIL; end
        end
        default: begin outcome_next = ST_BAD; fault_next = ER_SIZE; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SIZE; size_accum <= '0; data_left <= '0; decoded_total <= '0;
      byte_count <= '0; digit_seen <= 1'b0; name_hits <= 4'hF; name_pos <= '0;
      outcome <= ST_BUSY; fault <= ER_NONE; out_valid <= 1'b0;
    end else begin
      if (take) begin
        phase <= phase_next; size_accum <= size_accum_next; data_left <= data_left_next;
        decoded_total <= decoded_total_next; byte_count <= byte_count_next;
        digit_seen <= digit_seen_next; name_hits <= name_hits_next;
        name_pos <= name_pos_next; outcome <= outcome_next; fault <= fault_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (take) begin
      data_valid <= dv_next;
      data_byte  <= dv_next ? in_byte : 8'h00;
      status     <= outcome_next;
      error_code <= fault_next;
      consumed   <= byte_count_next;
    end
  end

endmodule
`default_nettype wire
